### hw/rtl/sevseg_pkg.sv
// shared types, constants and lookup functions for the seven-segment scan driver
package sevseg_pkg;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;
    localparam int VALUE_W     = 16;
    localparam int SHOWN_W     = 14;
    localparam int PROD_W      = 28;
    localparam int QPROD_W     = 27;
    localparam int QDIV_W      = 10;

    localparam logic [SHOWN_W-1:0] MAX_SHOWN    = 14'd9999;
    localparam logic [3:0]         ENABLES_OFF  = 4'hF;
    localparam logic [2:0]         LAST_BIT     = 3'd7;
    // q / 10 as (q * 6554) >> 16, exact for q up to 9999
    localparam logic [12:0]        TEN_RECIP    = 13'd6554;
    localparam int                 TEN_SHIFT    = 16;

    typedef enum logic [1:0] {
        POS_THOUSANDS = 2'd0,
        POS_HUNDREDS  = 2'd1,
        POS_TENS      = 2'd2,
        POS_ONES      = 2'd3
    } digit_pos_t;

    typedef struct packed {
        logic [7:0] segments;
        digit_pos_t pos;
    } seg_item_t;

    // segment pattern for one decimal digit, msb shifted first
    function automatic logic [7:0] seg_lookup(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'hEB;
            4'd1:    seg = 8'h88;
            4'd2:    seg = 8'hB3;
            4'd3:    seg = 8'hBA;
            4'd4:    seg = 8'hD8;
            4'd5:    seg = 8'h7A;
            4'd6:    seg = 8'h7B;
            4'd7:    seg = 8'hA8;
            4'd8:    seg = 8'hFB;
            4'd9:    seg = 8'hFA;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    // reciprocal multiplier for the place divisor of each position
    function automatic logic [SHOWN_W-1:0] place_recip(input digit_pos_t pos);
        logic [SHOWN_W-1:0] r;
        case (pos)
            POS_THOUSANDS: r = 14'd8389;   // 2^23 / 1000 rounded up
            POS_HUNDREDS:  r = 14'd10486;  // 2^20 / 100 rounded up
            POS_TENS:      r = 14'd13108;  // 2^17 / 10 rounded up
            POS_ONES:      r = 14'd1;
            default:       r = 14'd1;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] place_shift(input digit_pos_t pos);
        logic [4:0] s;
        case (pos)
            POS_THOUSANDS: s = 5'd23;
            POS_HUNDREDS:  s = 5'd20;
            POS_TENS:      s = 5'd17;
            POS_ONES:      s = 5'd0;
            default:       s = 5'd0;
        endcase
        return s;
    endfunction

    // active-low enable with only the given digit turned on
    function automatic logic [3:0] digit_enables_n(input digit_pos_t pos);
        logic [3:0] en;
        case (pos)
            POS_THOUSANDS: en = 4'b0111;
            POS_HUNDREDS:  en = 4'b1011;
            POS_TENS:      en = 4'b1101;
            POS_ONES:      en = 4'b1110;
            default:       en = ENABLES_OFF;
        endcase
        return en;
    endfunction

endpackage

### hw/rtl/seven_segment_scan_shift_out.sv
// top level: four-digit seven-segment scan driver with serial shift-out
//
// s_ channel: one transfer per scan tick, s_tdata holds the 16-bit value to
//   show; values above 9999 are shown as 9999
// m_ channel: eight transfers per tick, one per shift clock of the external
//   8-bit shift register, segment byte msb first
//   m_tdata[0]   serial data bit
//   m_tdata[4:1] active-low digit enables (bit 1 ones .. bit 4 thousands),
//                all off except on the eighth transfer
//   m_tlast      latch pulse, high on the eighth transfer of a tick
// the digit position starts at thousands and advances on every tick,
// wrapping after ones
// with the shifter idle, an accepted value passes the stage a and stage b
//   registers and is then loaded into the shifter, which raises m_tvalid
// the shifter sends one bit per cycle unless the receiver stalls; the
//   two-stage digit pipeline takes the next ticks while the shifter runs
// reset clears the pipeline and the shifter, position back to thousands
// a stalled receiver holds the current bit; the pipeline fills and then
//   s_tready drops
module seven_segment_scan_shift_out (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sevseg_pkg::IN_TDATA_W-1:0]   s_tdata,   // [15:0] display_value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sevseg_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [0] serial_data,
                                                           // [4:1] digit_enables,
                                                           // [7:5] zero
    output logic                                m_tlast    // latch_pulse
);
    import sevseg_pkg::*;

    logic       item_valid;
    logic       item_ready;
    seg_item_t  item;

    logic       shift_valid_reg, shift_valid_next;
    logic [7:0] shift_data_reg, shift_data_next;
    logic [2:0] bit_cnt_reg, bit_cnt_next;
    digit_pos_t shift_pos_reg, shift_pos_next;

    logic       last_bit;
    logic       out_xfer;

    // saturation, place division and segment lookup
    sevseg_digit_pipe u_digit_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    assign last_bit = (bit_cnt_reg == LAST_BIT);
    assign out_xfer = shift_valid_reg && m_tready;

    // shifter is free when empty or when the eighth bit leaves this cycle
    assign item_ready = !shift_valid_reg || (out_xfer && last_bit);

    assign m_tvalid = shift_valid_reg;
    assign m_tlast  = last_bit;
    assign m_tdata  = {3'b000,
                       last_bit ? digit_enables_n(shift_pos_reg) : ENABLES_OFF,
                       shift_data_reg[7]};

    always_comb begin
        shift_valid_next = shift_valid_reg;
        shift_data_next  = shift_data_reg;
        bit_cnt_next     = bit_cnt_reg;
        shift_pos_next   = shift_pos_reg;
        if (item_ready) begin
            // load the next byte, or go empty
            shift_valid_next = item_valid;
            shift_data_next  = item.segments;
            bit_cnt_next     = 3'd0;
            shift_pos_next   = item.pos;
        end else if (out_xfer) begin
            shift_data_next  = {shift_data_reg[6:0], 1'b0};
            bit_cnt_next     = bit_cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_valid_reg <= 1'b0;
            bit_cnt_reg     <= 3'd0;
        end else begin
            shift_valid_reg <= shift_valid_next;
            bit_cnt_reg     <= bit_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_data_reg <= shift_data_next;
        shift_pos_reg  <= shift_pos_next;
    end

endmodule

### hw/rtl/sevseg_digit_pipe.sv
// input register, position counter and digit extraction pipeline
module sevseg_digit_pipe (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sevseg_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                                item_valid,
    input  logic                                item_ready,
    output sevseg_pkg::seg_item_t               item
);
    import sevseg_pkg::*;

    logic                a_valid_reg, a_valid_next;
    logic [VALUE_W-1:0]  a_value_reg, a_value_next;
    digit_pos_t          a_pos_reg, a_pos_next;
    digit_pos_t          pos_reg, pos_next;
    logic                b_valid_reg, b_valid_next;
    logic [SHOWN_W-1:0]  b_quot_reg, b_quot_next;
    digit_pos_t          b_pos_reg, b_pos_next;

    logic                a_free, b_free, accept;
    logic [SHOWN_W-1:0]  shown;
    logic [PROD_W-1:0]   place_prod;
    logic [PROD_W-1:0]   place_quot;
    logic [QPROD_W-1:0]  ten_prod;
    logic [QDIV_W-1:0]   tens_part;
    logic [SHOWN_W-1:0]  tens_scaled;
    logic [SHOWN_W-1:0]  digit_full;

    assign b_free   = !b_valid_reg || item_ready;
    assign a_free   = !a_valid_reg || b_free;
    assign s_tready = a_free;
    assign accept   = s_tvalid && a_free;

    // stage a to b: saturate, then divide by the place value
    assign shown      = (a_value_reg > VALUE_W'(MAX_SHOWN)) ? MAX_SHOWN
                                                            : a_value_reg[SHOWN_W-1:0];
    assign place_prod = PROD_W'(shown) * PROD_W'(place_recip(a_pos_reg));
    assign place_quot = place_prod >> place_shift(a_pos_reg);

    // stage b to output: quotient mod 10, then segment lookup
    assign ten_prod    = QPROD_W'(b_quot_reg) * QPROD_W'(TEN_RECIP);
    assign tens_part   = ten_prod[TEN_SHIFT +: QDIV_W];
    assign tens_scaled = SHOWN_W'({tens_part, 3'b000}) + SHOWN_W'({tens_part, 1'b0});
    assign digit_full  = b_quot_reg - tens_scaled;

    assign item_valid    = b_valid_reg;
    assign item.segments = seg_lookup(digit_full[3:0]);
    assign item.pos      = b_pos_reg;

    always_comb begin
        a_valid_next = a_valid_reg;
        a_value_next = a_value_reg;
        a_pos_next   = a_pos_reg;
        pos_next     = pos_reg;
        b_valid_next = b_valid_reg;
        b_quot_next  = b_quot_reg;
        b_pos_next   = b_pos_reg;
        if (a_free) begin
            a_valid_next = s_tvalid;
        end
        if (accept) begin
            a_value_next = s_tdata[VALUE_W-1:0];
            a_pos_next   = pos_reg;
            pos_next     = digit_pos_t'(pos_reg + 2'd1);
        end
        if (b_free) begin
            b_valid_next = a_valid_reg;
            b_quot_next  = place_quot[SHOWN_W-1:0];
            b_pos_next   = a_pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            pos_reg     <= POS_THOUSANDS;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_value_reg <= a_value_next;
        a_pos_reg   <= a_pos_next;
        b_quot_reg  <= b_quot_next;
        b_pos_reg   <= b_pos_next;
    end

endmodule

### hw/rtl/sevseg_checker.sv
// port-level checks for the seven-segment scan driver and their bind
module sevseg_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [sevseg_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                                m_tlast
);
    import sevseg_pkg::*;

    // digits stay dark while bits are still shifting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[4:1] == ENABLES_OFF))
        else $error("digit enabled before latch");

    // exactly one digit turns on with the latch
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> ($countones(m_tdata[4:1]) == 3))
        else $error("latch without exactly one digit enabled");

    // a latch transfer is never followed directly by another latch
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tlast)
        else $error("latch repeated on consecutive transfers");

    // held output stays put under backpressure
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output changed while stalled");

endmodule

bind seven_segment_scan_shift_out sevseg_checker u_sevseg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### verif/seven_segment_checker.sv
`timescale 1ns / 1ps
// scoreboard for the seven-segment scan driver: predicts and checks each tick's shift-out
module seven_segment_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [sevseg_pkg::IN_TDATA_W-1:0]   s_tdata,    // [15:0] display_value
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [sevseg_pkg::OUT_TDATA_W-1:0]  m_tdata,    // [0] serial_data,
                                                            // [4:1] digit_enables,
                                                            // [7:5] zero
    input  logic                                m_tlast,    // latch_pulse
    output int                                  mismatches,
    output int                                  bits_pending,
    output int                                  ticks_seen,
    output int                                  ticks_saturated,
    output int                                  bits_seen
);
    import sevseg_pkg::*;

    localparam logic [13:0] SHOWN_LIMIT = 14'd9999;
    localparam logic [7:0]  SEG_PATTERN [0:9] = '{
        8'hEB, 8'h88, 8'hB3, 8'hBA, 8'hD8, 8'h7A, 8'h7B, 8'hA8, 8'hFB, 8'hFA
    };

    typedef struct packed {
        logic       serial;
        logic       latch;
        logic [3:0] enables;
    } shift_bit_t;

    shift_bit_t shift_bits_due[$];
    digit_pos_t scan_pos;
    int         fail_total;
    int         tick_total;
    int         sat_total;
    int         bit_total;

    task automatic note_mismatch(input string what);
        fail_total++;
        if (fail_total <= 10)
            $display("%0t mismatch: %s", $realtime, what);
    endtask

    always @(posedge aclk) begin : track
        logic [15:0] shown;
        int          place;
        logic [3:0]  digit;
        logic [7:0]  seg;
        shift_bit_t  e;

        if (!aresetn) begin
            shift_bits_due.delete();
            scan_pos = POS_THOUSANDS;
        end else begin
            // predict the eight shift clocks of an accepted tick
            if (s_tvalid && s_tready) begin
                tick_total++;
                shown = s_tdata;
                if (shown > SHOWN_LIMIT) begin
                    shown = SHOWN_LIMIT;
                    sat_total++;
                end
                case (scan_pos)
                    POS_THOUSANDS: place = 1000;
                    POS_HUNDREDS:  place = 100;
                    POS_TENS:      place = 10;
                    default:       place = 1;
                endcase
                digit = 4'((shown / place) % 10);
                seg   = SEG_PATTERN[digit];
                for (int k = 0; k < 8; k++) begin
                    e.serial  = seg[7-k];
                    e.latch   = (k == 7);
                    // only the digit just shifted is lit, and only at the latch
                    e.enables = (k == 7) ? (ENABLES_OFF & ~(4'b0001 << (3 - scan_pos)))
                                         : ENABLES_OFF;
                    shift_bits_due.push_back(e);
                end
                scan_pos = (scan_pos == POS_ONES) ? POS_THOUSANDS
                                                  : digit_pos_t'(scan_pos + 2'd1);
            end

            if (m_tvalid && m_tready) begin
                bit_total++;
                if (shift_bits_due.size() == 0) begin
                    note_mismatch($sformatf("unexpected transfer tdata=%h tlast=%b",
                                            m_tdata, m_tlast));
                end else begin
                    e = shift_bits_due.pop_front();
                    if (m_tdata[0] !== e.serial || m_tdata[4:1] !== e.enables ||
                        m_tlast !== e.latch || m_tdata[7:5] !== 3'b000)
                        note_mismatch($sformatf(
                            "exp bit %b last %b en %b, got bit %b last %b en %b pad %b",
                            e.serial, e.latch, e.enables, m_tdata[0], m_tlast,
                            m_tdata[4:1], m_tdata[7:5]));
                end
            end
        end

        mismatches      <= fail_total;
        bits_pending    <= shift_bits_due.size();
        ticks_seen      <= tick_total;
        ticks_saturated <= sat_total;
        bits_seen       <= bit_total;
    end

    initial begin
        fail_total      = 0;
        tick_total      = 0;
        sat_total       = 0;
        bit_total       = 0;
        mismatches      = 0;
        bits_pending    = 0;
        ticks_seen      = 0;
        ticks_saturated = 0;
        bits_seen       = 0;
    end

endmodule

### verif/tb_seven_segment_scan_shift_out.sv
`timescale 1ns / 1ps
// testbench top for the seven-segment scan driver: stimulus, flow control and verdict
module tb_seven_segment_scan_shift_out;
    import sevseg_pkg::*;

    // watchdog limit on cycles without any transfer, well above the long hold-off
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    // time for the pipeline and one full shift of a segment byte, with margin
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_TICKS [0:2] = '{120, 120, 110};
    localparam logic [15:0] DIRECTED_VALUES [0:19] = '{
        16'd0,     16'd65535, 16'd9999,  16'd10000,
        16'd1234,  16'd5678,  16'd9012,  16'd3456,
        16'd7890,  16'd1111,  16'd8888,  16'd1000,
        16'd1,     16'd9998,  16'd32768, 16'd4321,
        16'd10001, 16'd5555,  16'd7777,  16'd2468
    };

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    int   send_idle_pct = 15;
    int   recv_idle_pct = 77;
    logic hold_go       = 1'b0;
    logic hold_rx       = 1'b0;
    int   quiet_cycles  = 0;

    int   mismatches;
    int   bits_pending;
    int   ticks_seen;
    int   ticks_saturated;
    int   bits_seen;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    seven_segment_scan_shift_out dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    seven_segment_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .bits_pending    (bits_pending),
        .ticks_seen      (ticks_seen),
        .ticks_saturated (ticks_saturated),
        .bits_seen       (bits_seen)
    );

    // receiver: random stalls, forced low during the long hold-off
    always @(posedge aclk) begin
        m_tready <= hold_rx ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver hold-off, counted here so the sender keeps pushing meanwhile
    initial begin
        wait (hold_go);
        @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    // watchdog: ends the run if no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d bits still due",
                     quiet_cycles, bits_pending);
            $display("[seven_segment_scan_shift_out] ERROR");
            $finish;
        end
    end

    // one scan tick on the input channel, with random idle cycles ahead of it;
    // valid stays high into the next tick unless that tick idles first
    task automatic send_tick(input logic [15:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // stop offering and let every predicted bit come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (bits_pending != 0);
    endtask

    initial begin
        logic [15:0] value;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, saturation edges, digit patterns, wrap
        foreach (DIRECTED_VALUES[i])
            send_tick(DIRECTED_VALUES[i]);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 77;
                end
                1: begin
                    send_idle_pct = 77;
                    recv_idle_pct = 15;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < RANDOM_TICKS[phase]; i++) begin
                // start the long hold-off with the sender running flat out
                if (phase == 2 && i == 20)
                    hold_go = 1'b1;
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5, 6: value = 16'($urandom_range(9999));
                    7:                   value = 16'($urandom_range(65535, 10000));
                    8:                   value = 16'($urandom);
                    default:             value = 16'($urandom_range(10010, 9990));
                endcase
                send_tick(value);
            end
            // sender pauses until the block has emptied
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d scan ticks (%0d saturated) and %0d shifted bits",
                 ticks_seen, ticks_saturated, bits_seen);
        $display("under three idle mixes, a %0d-cycle receiver hold-off and full-rate flow",
                 HOLD_CYCLES);
        if (mismatches == 0 && bits_pending == 0) begin
            $display("[seven_segment_scan_shift_out] OK");
        end else begin
            $display("%0d mismatches, %0d bits never arrived", mismatches, bits_pending);
            $display("[seven_segment_scan_shift_out] ERROR");
        end
        $finish;
    end

endmodule

### seven_segment_scan_shift_out.f
hw/rtl/sevseg_pkg.sv
hw/rtl/sevseg_digit_pipe.sv
hw/rtl/seven_segment_scan_shift_out.sv
hw/rtl/sevseg_checker.sv
verif/seven_segment_checker.sv
verif/tb_seven_segment_scan_shift_out.sv
